/* rtl/core/twfa_pkg.sv */
// Shared widths, constants and CORDIC arctangent table for the true wind block.
package twfa_pkg;
  localparam int SPEED_W = 16;
  localparam int ANGLE_W = 15;
  localparam int TWS_W = 17;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int TAB_LEN = 24;
  localparam int DW = 40;
  localparam int ZW = 32;
  localparam int QUARTER = 5760;
  localparam int HALF = 11520;
  localparam int TURN = 23040;
  localparam int DEG_SHIFT = 16;
  localparam longint GAIN_Q30 = 64'd652032874;
  localparam longint SPD_MAX = 64'd131070;

  function automatic logic signed [ZW-1:0] atan_entry(input int i);
    logic signed [ZW-1:0] v;
    begin
      case (i)
        0: v = 32'sd188743680;
        1: v = 32'sd111421900;
        2: v = 32'sd58872272;
        3: v = 32'sd29884485;
        4: v = 32'sd15000234;
        5: v = 32'sd7507429;
        6: v = 32'sd3754631;
        7: v = 32'sd1877430;
        8: v = 32'sd938729;
        9: v = 32'sd469366;
        10: v = 32'sd234683;
        11: v = 32'sd117342;
        12: v = 32'sd58671;
        13: v = 32'sd29335;
        14: v = 32'sd14668;
        15: v = 32'sd7334;
        16: v = 32'sd3667;
        17: v = 32'sd1833;
        18: v = 32'sd917;
        19: v = 32'sd458;
        20: v = 32'sd229;
        21: v = 32'sd115;
        22: v = 32'sd57;
        default: v = 32'sd29;
      endcase
      return v;
    end
  endfunction
endpackage

/* rtl/core/twfa_if.sv */
// Valid/ready channel interfaces for the true wind block.
interface twfa_in_if import twfa_pkg::*;;
  logic valid;
  logic ready;
  logic [SPEED_W-1:0] boat_speed;
  logic [SPEED_W-1:0] apparent_wind_speed;
  logic [ANGLE_W-1:0] wind_direction;
  logic [ANGLE_W-1:0] boat_heading;
  modport source (output valid, boat_speed, apparent_wind_speed, wind_direction,
    boat_heading, input ready);
  modport sink (input valid, boat_speed, apparent_wind_speed, wind_direction,
    boat_heading, output ready);
endinterface

interface twfa_out_if import twfa_pkg::*;;
  logic valid;
  logic ready;
  logic [TWS_W-1:0] true_wind_speed;
  logic [ANGLE_W-1:0] true_wind_direction;
  modport source (output valid, true_wind_speed, true_wind_direction, input ready);
  modport sink (input valid, true_wind_speed, true_wind_direction, output ready);
endinterface

/* rtl/core/true_wind_from_apparent.sv */
// True wind from apparent wind: pipelined dual CORDIC, one item per cycle while the output is not stalled.
//
// Channels: in_ch carries boat speed, apparent wind speed, wind direction
// and heading; out_ch carries true wind speed and direction. Both are
// valid/ready; an item moves when valid and ready are high at a clock edge.
// Throughput: one item per cycle while the output is not stalled. Stages:
// prepare, N rotation stages, offset, N vectoring stages, gain multiply,
// direction and wrap, where N is CORDIC_STEPS capped at TAB_LEN.
// The whole pipeline advances together whenever the output register is
// empty or is being taken, so a stall at the output freezes every stage
// and no item is lost or repeated.
// Reset (rst, synchronous) clears all valid bits; payload is not cleared.
// Degenerate items (zero apparent speed or zero relative angle) travel
// through the pipe flagged and leave as zero speed and zero direction.
module true_wind_from_apparent import twfa_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input logic clk,
  input logic rst,
  twfa_in_if.sink in_ch,
  twfa_out_if.source out_ch
);
  localparam int N = (CORDIC_STEPS > TAB_LEN) ? TAB_LEN : CORDIC_STEPS;

  typedef struct packed {
    logic signed [DW-1:0] x;
    logic signed [DW-1:0] y;
    logic signed [ZW-1:0] z;
    logic signed [16:0] bs;
    logic signed [16:0] e;
    logic [ANGLE_W-1:0] hd;
    logic zero;
  } stg_t;

  logic adv;
  logic [2*N+3:0] vld;
  stg_t rot [0:N];
  stg_t vec [0:N];
  stg_t vec0_next;
  logic signed [DW+31:0] prod;
  stg_t mul_s;
  logic [TWS_W-1:0] tws;
  logic [ANGLE_W-1:0] twd;

  assign adv = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = adv;

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (adv) vld <= {vld[2*N+2:0], in_ch.valid};
  end
  assign out_ch.valid = vld[2*N+3];

  logic signed [16:0] e0, e1;
  logic signed [16:0] ang0;
  always_comb begin
    e0 = $signed({2'b0, in_ch.boat_heading}) - $signed({2'b0, in_ch.wind_direction});
    if (e0 > 17'sd11520) e1 = e0 - 17'sd23040;
    else if (e0 < -17'sd11520) e1 = e0 + 17'sd23040;
    else e1 = e0;
    ang0 = e1[16] ? -e1 : e1;
  end

  logic [47:0] awsk;
  assign awsk = 48'(in_ch.apparent_wind_speed) * 48'(GAIN_Q30);

  always_ff @(posedge clk) begin
    if (adv) begin
      rot[0].x <= $signed({8'b0, awsk[47:16]});
      rot[0].y <= '0;
      rot[0].z <= ZW'((17'sd5760 - ang0)) <<< DEG_SHIFT;
      rot[0].bs <= $signed({1'b0, in_ch.boat_speed});
      rot[0].e <= e1;
      rot[0].hd <= in_ch.boat_heading;
      rot[0].zero <= (in_ch.apparent_wind_speed == '0) || (ang0 == '0);
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_rot
    stg_t rot_next;
    always_comb begin
      rot_next = rot[i];
      if (!rot[i].z[ZW-1]) begin
        rot_next.x = rot[i].x - (rot[i].y >>> i);
        rot_next.y = rot[i].y + (rot[i].x >>> i);
        rot_next.z = rot[i].z - atan_entry(i);
      end else begin
        rot_next.x = rot[i].x + (rot[i].y >>> i);
        rot_next.y = rot[i].y - (rot[i].x >>> i);
        rot_next.z = rot[i].z + atan_entry(i);
      end
    end
    always_ff @(posedge clk) begin
      if (adv) rot[i+1] <= rot_next;
    end
  end

  always_comb begin
    vec0_next = rot[N];
    vec0_next.x = rot[N].x[DW-1] ? '0 : rot[N].x;
    vec0_next.y = rot[N].y - (DW'(rot[N].bs) <<< 14);
    vec0_next.z = '0;
  end

  always_ff @(posedge clk) begin
    if (adv) vec[0] <= vec0_next;
  end

  for (genvar i = 0; i < N; i++) begin : g_vec
    stg_t vec_next;
    always_comb begin
      vec_next = vec[i];
      if (!(vec[i].x == '0 && vec[i].y == '0)) begin
        if (vec[i].y[DW-1]) begin
          vec_next.x = vec[i].x - (vec[i].y >>> i);
          vec_next.y = vec[i].y + (vec[i].x >>> i);
          vec_next.z = vec[i].z - atan_entry(i);
        end else begin
          vec_next.x = vec[i].x + (vec[i].y >>> i);
          vec_next.y = vec[i].y - (vec[i].x >>> i);
          vec_next.z = vec[i].z + atan_entry(i);
        end
      end
    end
    always_ff @(posedge clk) begin
      if (adv) vec[i+1] <= vec_next;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod <= (DW+32)'(vec[N].x) * (DW+32)'(GAIN_Q30) + ((DW+32)'(1) <<< 43);
      mul_s <= vec[N];
    end
  end

  logic signed [DW+31:0] spd;
  logic signed [ZW:0] relw;
  logic signed [16:0] rel, t0, t1;
  always_comb begin
    spd = prod >>> 44;
    if (spd > (DW+32)'(SPD_MAX)) spd = (DW+32)'(SPD_MAX);
    relw = ((ZW+1)'(QUARTER) <<< DEG_SHIFT) - (ZW+1)'(mul_s.z) + (ZW+1)'(32768);
    relw = relw >>> DEG_SHIFT;
    if (relw < 0) rel = '0;
    else if (relw > (ZW+1)'(HALF)) rel = 17'sd11520;
    else rel = relw[16:0];
    if (mul_s.e > 0 && mul_s.e < 17'sd11520) t0 = $signed({2'b0, mul_s.hd}) - rel;
    else t0 = $signed({2'b0, mul_s.hd}) + rel;
    if (t0 < 0) t1 = t0 + 17'sd23040;
    else if (t0 > 17'sd23040) t1 = t0 - 17'sd23040;
    else t1 = t0;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tws <= mul_s.zero ? '0 : spd[TWS_W-1:0];
      twd <= mul_s.zero ? '0 : t1[ANGLE_W-1:0];
    end
  end

  assign out_ch.true_wind_speed = tws;
  assign out_ch.true_wind_direction = twd;

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(tws) && $stable(twd))
    else $error("output changed under stall");
  a_no_accept_stall: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.ready |-> !in_ch.ready)
    else $error("input taken while pipeline stalled");
  a_dir_range: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> twd <= ANGLE_W'(TURN))
    else $error("direction out of range");
  a_spd_range: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> tws <= TWS_W'(SPD_MAX))
    else $error("speed out of range");
endmodule

/* tb/tb.sv */
// Testbench for the true wind block: directed table, random stream, CORDIC predictor.
module tb;
  import twfa_pkg::*;

  logic clk;
  logic rst;
  twfa_in_if in_ch();
  twfa_out_if out_ch();

  true_wind_from_apparent dut (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  typedef struct packed {
    logic [TWS_W-1:0] spd;
    logic [ANGLE_W-1:0] dir;
  } wind_t;

  typedef struct {
    logic [SPEED_W-1:0] bs;
    logic [SPEED_W-1:0] aws;
    logic [ANGLE_W-1:0] wd;
    logic [ANGLE_W-1:0] hd;
    bit known;
    wind_t res;
  } row_t;

  localparam int LATENCY = 2 * CORDIC_STEPS_DEF + 4;
  localparam int N_RANDOM = 1400;
  localparam int CYCLE_LIMIT = 400000;

  wind_t wind_q[$];
  row_t rows[$];
  int errors;
  int cycles;
  bit stim_done;

  function automatic longint asr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic wind_t true_wind(logic [SPEED_W-1:0] bs_i, logic [SPEED_W-1:0] aws_i,
                                      logic [ANGLE_W-1:0] wd_i, logic [ANGLE_W-1:0] hd_i);
    longint bs, aws, wd, hd, e, ang, x, y, z, t, rel, spd, dx, dy, tab;
    int i;
    wind_t r;
    bs = longint'(bs_i);
    aws = longint'(aws_i);
    wd = longint'(wd_i);
    hd = longint'(hd_i);
    r = '0;
    e = hd - wd;
    if (e > HALF) e -= TURN;
    else if (e < -HALF) e += TURN;
    ang = e < 0 ? -e : e;
    if (aws == 0 || ang == 0) return r;
    x = (aws * GAIN_Q30) >>> 16;
    y = 0;
    z = (QUARTER - ang) <<< DEG_SHIFT;
    for (i = 0; i < CORDIC_STEPS_DEF; i++) begin
      dx = asr(y, i);
      dy = asr(x, i);
      tab = longint'(atan_entry(i));
      if (z >= 0) begin
        x -= dx; y += dy; z -= tab;
      end else begin
        x += dx; y -= dy; z += tab;
      end
    end
    if (x < 0) x = 0;
    y -= bs <<< 14;
    z = 0;
    if (!(x == 0 && y == 0)) begin
      for (i = 0; i < CORDIC_STEPS_DEF; i++) begin
        dx = asr(y, i);
        dy = asr(x, i);
        tab = longint'(atan_entry(i));
        if (y < 0) begin
          x -= dx; y += dy; z -= tab;
        end else begin
          x += dx; y -= dy; z += tab;
        end
      end
    end
    spd = (x * GAIN_Q30 + (64'sd1 <<< 43)) >>> 44;
    if (spd > SPD_MAX) spd = SPD_MAX;
    rel = (longint'(QUARTER) <<< DEG_SHIFT) - z;
    rel = asr(rel + (64'sd1 <<< (DEG_SHIFT - 1)), DEG_SHIFT);
    if (rel < 0) rel = 0;
    if (rel > HALF) rel = HALF;
    if (e > 0 && e < HALF) t = hd - rel;
    else t = hd + rel;
    if (t < 0) t += TURN;
    if (t > TURN) t -= TURN;
    r.spd = spd[TWS_W-1:0];
    r.dir = t[ANGLE_W-1:0];
    return r;
  endfunction

  function automatic void add_row(int bs, int aws, int wd, int hd, int known, int spd, int dir);
    row_t r;
    r.bs = SPEED_W'(bs);
    r.aws = SPEED_W'(aws);
    r.wd = ANGLE_W'(wd);
    r.hd = ANGLE_W'(hd);
    r.known = (known != 0);
    r.res.spd = TWS_W'(spd);
    r.res.dir = ANGLE_W'(dir);
    rows.push_back(r);
  endfunction

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // receiver stall pattern
  int stall_mode;
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
      stall_mode <= 0;
    end else begin
      if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= ($urandom_range(0, 3) != 0);
        2: out_ch.ready <= ($urandom_range(0, 1) != 0);
        default: out_ch.ready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // check results
  always @(posedge clk) begin
    wind_t exp_w;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (wind_q.size() == 0) begin
        $display("%0t: unexpected item spd=%0d dir=%0d", $time,
                 out_ch.true_wind_speed, out_ch.true_wind_direction);
        errors++;
      end else begin
        exp_w = wind_q.pop_front();
        if (out_ch.true_wind_speed !== exp_w.spd) begin
          $display("%0t: speed expected %0d actual %0d", $time, exp_w.spd,
                   out_ch.true_wind_speed);
          errors++;
        end
        if (out_ch.true_wind_direction !== exp_w.dir) begin
          $display("%0t: direction expected %0d actual %0d", $time, exp_w.dir,
                   out_ch.true_wind_direction);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL true_wind_from_apparent");
      $finish;
    end
  end

  task automatic send(row_t r);
    wind_t w;
    in_ch.valid <= 1'b1;
    in_ch.boat_speed <= r.bs;
    in_ch.apparent_wind_speed <= r.aws;
    in_ch.wind_direction <= r.wd;
    in_ch.boat_heading <= r.hd;
    do @(posedge clk); while (!in_ch.ready);
    w = true_wind(r.bs, r.aws, r.wd, r.hd);
    if (r.known && w !== r.res) begin
      $display("%0t: table row expected spd=%0d dir=%0d predicted spd=%0d dir=%0d",
               $time, r.res.spd, r.res.dir, w.spd, w.dir);
      errors++;
    end
    wind_q.push_back(r.known ? r.res : w);
  endtask

  task automatic idle(int n);
    if (n > 0) begin
      in_ch.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  function automatic int rand_angle();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 32767);
      1: return TURN;
      2: return 0;
      default: return $urandom_range(0, TURN);
    endcase
  endfunction

  function automatic int rand_speed();
    case ($urandom_range(0, 4))
      0: return $urandom_range(0, 65535);
      1: return $urandom_range(0, 3) == 0 ? 0 : 65535;
      default: return $urandom_range(0, 8000);
    endcase
  endfunction

  initial begin
    row_t r;
    int burst, k, pause_at;
    errors = 0;
    cycles = 0;
    stim_done = 0;
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.boat_speed = '0;
    in_ch.apparent_wind_speed = '0;
    in_ch.wind_direction = '0;
    in_ch.boat_heading = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // degenerate rows: zero apparent speed, zero relative angle
    add_row(0, 0, 0, 0, 1, 0, 0);
    add_row(65535, 0, 23040, 100, 1, 0, 0);
    add_row(1000, 5000, 7000, 7000, 1, 0, 0);
    add_row(1000, 5000, 0, 23040, 1, 0, 0);
    add_row(65535, 65535, 32767, 32767, 1, 0, 0);
    // predicted rows
    add_row(0, 65535, 0, 11520, 0, 0, 0);
    add_row(65535, 65535, 0, 11520, 0, 0, 0);
    add_row(65535, 1, 5760, 0, 0, 0, 0);
    add_row(0, 65535, 5760, 0, 0, 0, 0);
    add_row(0, 65535, 0, 5760, 0, 0, 0);
    add_row(2560, 2560, 0, 11520, 0, 0, 0);
    add_row(1280, 2560, 100, 23000, 0, 0, 0);
    add_row(1280, 2560, 23000, 100, 0, 0, 0);
    add_row(3000, 4000, 32767, 0, 0, 0, 0);
    add_row(3000, 4000, 0, 32767, 0, 0, 0);
    add_row(21845, 43690, 21845, 10922, 0, 0, 0);
    add_row(43690, 21845, 10922, 21845, 0, 0, 0);
    add_row(256, 256, 1, 0, 0, 0, 0);
    add_row(256, 65535, 0, 1, 0, 0, 0);
    add_row(5000, 300, 11519, 0, 0, 0, 0);
    add_row(5000, 300, 0, 11521, 0, 0, 0);
    foreach (rows[i]) send(rows[i]);
    idle(3);

    pause_at = $urandom_range(200, 1000);
    k = 0;
    while (k < N_RANDOM) begin
      burst = $urandom_range(0, 3) == 0 ? $urandom_range(40, 120) : $urandom_range(1, 12);
      repeat (burst) begin
        if (k < N_RANDOM) begin
          r.bs = SPEED_W'(rand_speed());
          r.aws = SPEED_W'(rand_speed());
          r.wd = ANGLE_W'(rand_angle());
          r.hd = ANGLE_W'(rand_angle());
          r.known = 1'b0;
          r.res = '0;
          send(r);
          k++;
          if (k == pause_at) begin
            in_ch.valid <= 1'b0;
            while (wind_q.size() != 0) @(posedge clk);
          end
        end
      end
      idle($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8));
    end
    in_ch.valid <= 1'b0;
    while (wind_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (errors == 0) begin
      $display("PASS true_wind_from_apparent");
    end else begin
      $display("FAIL true_wind_from_apparent");
    end
    $finish;
  end
endmodule
